// File: rtl/scpa_pkg.sv
// Package for the size class pool allocator: field widths, codes, state type.
// No dependencies; every other file of the block except scpa_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package scpa_pkg;

    // field widths of the request, response and configuration beats
    localparam int KIND_W     = 1;
    localparam int REQ_W      = 16;
    localparam int CLS_W      = 2;
    localparam int SLOT_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int BYTES_W    = 25;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;
    localparam int SIZE_W     = 17;
    localparam int CNT_W      = 9;

    // classes that have size and count registers
    localparam int REG_CLASSES = 4;
    // slot numbers are eight bits wide
    localparam int MAX_SLOTS   = 256;
    // allocation granule in bytes
    localparam int ALIGN_BYTES = 4;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_CLASS  = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } t_status;

    // control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP
    } t_state;

endpackage

`default_nettype wire

// File: rtl/scpa_req_if.sv
// Request channel of the pool allocator: valid/ready plus one request beat.
// Depends on scpa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface scpa_req_if import scpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [REQ_W-1:0]  req_size;
    logic [CLS_W-1:0]  free_class;
    logic [SLOT_W-1:0] free_slot;

    modport source (output valid, kind, req_size, free_class, free_slot, input ready);
    modport sink   (input valid, kind, req_size, free_class, free_slot, output ready);
endinterface

`default_nettype wire

// File: rtl/scpa_rsp_if.sv
// Response channel of the pool allocator: valid/ready plus one result beat.
// Depends on scpa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface scpa_rsp_if import scpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CLS_W-1:0]    out_class;
    logic [SLOT_W-1:0]   out_slot;
    logic [BYTES_W-1:0]  bytes_free;

    modport source (output valid, status, out_class, out_slot, bytes_free, input ready);
    modport sink   (input valid, status, out_class, out_slot, bytes_free, output ready);
endinterface

`default_nettype wire

// File: rtl/scpa_cfg_if.sv
// Configuration write channel of the pool allocator: valid/ready, index, data.
// Depends on scpa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface scpa_cfg_if import scpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/scpa_ram.sv
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/size_class_pool_allocator_core.sv
// Top level of the size class pool allocator: class registers, sequencer,
// free-list and busy-bit memories. Depends on scpa_pkg, the three channel
// interfaces and scpa_ram.
//
//   port    | dir | beat contents
//   --------+-----+-----------------------------------------------
//   i_req   | in  | kind, req_size, free_class, free_slot
//   o_rsp   | out | status, out_class, out_slot, bytes_free
//   i_cfg   | in  | index (register number), data (write value)
//
// Each item passes through the accept cycle, which does the class lookup and issues
// the memory read, and then the execute state, which reads back, updates the class
// pointers and writes the memories, loading the output register.
// A nonzero slot count write to a present class runs a sweep over its new slots that
// rebuilds the free list and clears the busy bits of that class; neither channel is ready then.
// Reset clears all class registers; the memories need no clearing pass.
// A full output register stalls the execute cycle until the beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module size_class_pool_allocator_core
    import scpa_pkg::*;
#(
    parameter int NUM_CLASSES     = 4,
    parameter int SLOTS_PER_CLASS = 256
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    scpa_req_if.sink   i_req,
    scpa_rsp_if.source o_rsp,
    scpa_cfg_if.sink   i_cfg
);

    localparam int CW      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int IW      = $clog2(SLOTS_PER_CLASS);
    localparam int FW      = $clog2(SLOTS_PER_CLASS + 1);
    localparam int TW      = IW + 2;
    localparam int AW      = CW + IW;
    localparam int DEPTH   = 2 ** AW;
    localparam int PROD_W  = SIZE_W + CNT_W;
    localparam int LIMIT_I = (SLOTS_PER_CLASS < MAX_SLOTS) ? SLOTS_PER_CLASS : MAX_SLOTS;
    localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(LIMIT_I);
    localparam logic [FW-1:0]    FILL_FULL  = FW'(SLOTS_PER_CLASS);
    localparam logic [IW-1:0]    HEAD_LAST  = IW'(SLOTS_PER_CLASS - 1);
    localparam logic [TW-1:0]    TAIL_WRAP  = TW'(SLOTS_PER_CLASS);
    localparam logic [SIZE_W-1:0] ALIGN_MASK = SIZE_W'(ALIGN_BYTES - 1);

    // per-class registers
    logic [SIZE_W-1:0]  r_size  [NUM_CLASSES];
    logic [CNT_W-1:0]   r_lim   [NUM_CLASSES];
    logic [IW-1:0]      r_head  [NUM_CLASSES];
    logic [FW-1:0]      r_fill  [NUM_CLASSES];
    logic [BYTES_W-1:0] r_bytes [NUM_CLASSES];

    // sequencer
    t_state r_state, n_state;
    logic   in_rdy, cfg_rdy, in_fire, cfg_fire, commit, sweep_wr, out_free;

    // captured request
    logic [KIND_W-1:0] r_kind;
    logic [CW-1:0]     r_cls;
    logic              r_cls_ok;
    logic [CLS_W-1:0]  r_req_cls;
    logic [SLOT_W-1:0] r_slot_in;
    t_status           r_pre;

    // sweep
    logic [CW-1:0]    r_sw_cls;
    logic [CNT_W-1:0] r_sw_cnt;
    logic [CNT_W-1:0] r_sw_last;

    // output register
    logic               r_out_valid;
    t_status            r_out_status;
    logic [CLS_W-1:0]   r_out_cls;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [BYTES_W-1:0] r_out_bytes;

    // memory ports
    logic              fifo_we, busy_we;
    logic [AW-1:0]     fifo_waddr, fifo_raddr, busy_waddr, busy_raddr;
    logic [SLOT_W-1:0] fifo_wdata, fifo_rdata;
    logic [0:0]        busy_wdata, busy_rdata;

    // handshakes
    assign cfg_rdy     = (r_state == S_IDLE);
    assign in_rdy      = (r_state == S_IDLE) && !i_cfg.valid;
    assign in_fire     = i_req.valid && in_rdy;
    assign cfg_fire    = i_cfg.valid && cfg_rdy;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = in_rdy;
    assign i_cfg.ready = cfg_rdy;

    // configuration decode
    logic                  cfg_is_size, cfg_is_slots, cfg_cls_ok;
    logic [CW-1:0]         cfg_cls;
    logic [SIZE_W-1:0]     cfg_size;
    logic [CNT_W-1:0]      cfg_cnt_raw, cfg_cnt;
    logic [PROD_W-1:0]     prod_size, prod_cnt;

    assign cfg_is_size  = i_cfg.index < CFG_IDX_W'(REG_CLASSES);
    assign cfg_is_slots = !cfg_is_size && (i_cfg.index < CFG_IDX_W'(2 * REG_CLASSES));
    assign cfg_cls_ok   = int'(i_cfg.index[CLS_W-1:0]) < NUM_CLASSES;
    assign cfg_cls      = CW'(i_cfg.index[CLS_W-1:0]);
    assign cfg_size     = i_cfg.data[SIZE_W-1:0];
    assign cfg_cnt_raw  = i_cfg.data[CNT_W-1:0];
    assign cfg_cnt      = (cfg_cnt_raw > SLOT_LIMIT) ? SLOT_LIMIT : cfg_cnt_raw;
    assign prod_size    = cfg_size * CNT_W'(r_fill[cfg_cls]);
    assign prod_cnt     = r_size[cfg_cls] * cfg_cnt;

    // class lookup and free checks on the incoming beat
    logic [SIZE_W-1:0] want;
    logic              hit, fc_ok, free_bad;
    logic [CW-1:0]     hit_cls, fcx;

    always_comb begin
        want    = (SIZE_W'(i_req.req_size) + ALIGN_MASK) & ~ALIGN_MASK;
        hit     = 1'b0;
        hit_cls = '0;
        // scan downward so the lowest matching class wins
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (c < REG_CLASSES && r_size[c] != '0 && r_size[c] == want) begin
                hit     = 1'b1;
                hit_cls = CW'(c);
            end
        end
        fc_ok    = int'(i_req.free_class) < NUM_CLASSES;
        fcx      = CW'(i_req.free_class);
        free_bad = !fc_ok || (CNT_W'(i_req.free_slot) >= r_lim[fcx])
                   || (r_fill[fcx] >= FILL_FULL);
    end

    // capture request and lookup outcome
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind <= i_req.kind;
            if (i_req.kind == KIND_ALLOC) begin
                r_cls     <= hit_cls;
                r_cls_ok  <= hit;
                r_req_cls <= CLS_W'(hit_cls);
                r_slot_in <= i_req.free_slot;
                if (!hit) begin
                    r_pre <= ST_NO_CLASS;
                end else if (r_fill[hit_cls] == '0) begin
                    r_pre <= ST_EXHAUSTED;
                end else begin
                    r_pre <= ST_OK;
                end
            end else begin
                r_cls     <= fcx;
                r_cls_ok  <= fc_ok;
                r_req_cls <= i_req.free_class;
                r_slot_in <= i_req.free_slot;
                r_pre     <= free_bad ? ST_NOT_ALLOC : ST_OK;
            end
        end
    end

    // execute cycle: results and pointer updates
    logic [BYTES_W-1:0] cur_bytes, size_ext, n_bytes;
    logic [IW-1:0]      n_head, tail;
    logic [FW-1:0]      n_fill;
    logic [TW-1:0]      tail_sum;
    logic               exec_ok, alloc_ok, free_ok;
    t_status            res_status;
    logic [CLS_W-1:0]   res_cls;
    logic [SLOT_W-1:0]  res_slot;
    logic [BYTES_W-1:0] res_bytes;

    always_comb begin
        cur_bytes = r_cls_ok ? r_bytes[r_cls] : '0;
        size_ext  = BYTES_W'(r_size[r_cls]);
        alloc_ok  = (r_pre == ST_OK) && (r_kind == KIND_ALLOC);
        free_ok   = (r_pre == ST_OK) && (r_kind == KIND_FREE) && busy_rdata[0];
        exec_ok   = alloc_ok || free_ok;
        tail_sum  = TW'(r_head[r_cls]) + TW'(r_fill[r_cls]);
        tail      = (tail_sum >= TAIL_WRAP) ? IW'(tail_sum - TAIL_WRAP) : IW'(tail_sum);
        if (alloc_ok) begin
            n_head  = (r_head[r_cls] == HEAD_LAST) ? '0 : IW'(r_head[r_cls] + 1'b1);
            n_fill  = FW'(r_fill[r_cls] - 1'b1);
            n_bytes = (cur_bytes >= size_ext) ? BYTES_W'(cur_bytes - size_ext) : '0;
        end else begin
            n_head  = r_head[r_cls];
            n_fill  = FW'(r_fill[r_cls] + 1'b1);
            n_bytes = BYTES_W'(cur_bytes + size_ext);
        end
        // response fields
        res_cls   = r_req_cls;
        res_slot  = r_slot_in;
        res_bytes = cur_bytes;
        if (r_pre == ST_NO_CLASS) begin
            res_status = ST_NO_CLASS;
            res_cls    = '0;
            res_slot   = '0;
            res_bytes  = '0;
        end else if (r_pre == ST_EXHAUSTED) begin
            res_status = ST_EXHAUSTED;
            res_slot   = '0;
        end else if (alloc_ok) begin
            res_status = ST_OK;
            res_slot   = fifo_rdata;
            res_bytes  = n_bytes;
        end else if (free_ok) begin
            res_status = ST_OK;
            res_bytes  = n_bytes;
        end else begin
            res_status = ST_NOT_ALLOC;
        end
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        commit   = 1'b0;
        sweep_wr = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (cfg_fire && cfg_is_slots && cfg_cls_ok && cfg_cnt != '0) begin
                    n_state = S_SWEEP;
                end else if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                sweep_wr = 1'b1;
                if (r_sw_cnt == r_sw_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sweep counter
    always_ff @(posedge i_clk) begin
        if (cfg_fire && cfg_is_slots) begin
            r_sw_cls  <= cfg_cls;
            r_sw_cnt  <= '0;
            r_sw_last <= CNT_W'(cfg_cnt - 1'b1);
        end else if (sweep_wr) begin
            r_sw_cnt <= CNT_W'(r_sw_cnt + 1'b1);
        end
    end

    // per-class registers: config writes and commits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_size[c]  <= '0;
                r_lim[c]   <= '0;
                r_head[c]  <= '0;
                r_fill[c]  <= '0;
                r_bytes[c] <= '0;
            end
        end else begin
            if (cfg_fire && cfg_cls_ok && cfg_is_size) begin
                r_size[cfg_cls]  <= cfg_size;
                r_bytes[cfg_cls] <= BYTES_W'(prod_size);
            end
            if (cfg_fire && cfg_cls_ok && cfg_is_slots) begin
                r_lim[cfg_cls]   <= cfg_cnt;
                r_head[cfg_cls]  <= '0;
                r_fill[cfg_cls]  <= FW'(cfg_cnt);
                r_bytes[cfg_cls] <= BYTES_W'(prod_cnt);
            end
            if (commit && exec_ok) begin
                r_head[r_cls]  <= n_head;
                r_fill[r_cls]  <= n_fill;
                r_bytes[r_cls] <= n_bytes;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_status <= res_status;
            r_out_cls    <= res_cls;
            r_out_slot   <= res_slot;
            r_out_bytes  <= res_bytes;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.out_class  = r_out_cls;
    assign o_rsp.out_slot   = r_out_slot;
    assign o_rsp.bytes_free = r_out_bytes;

    // memory port muxing: sweep rebuild or commit
    always_comb begin
        fifo_raddr = {hit_cls, r_head[hit_cls]};
        busy_raddr = {fcx, IW'(i_req.free_slot)};
        if (sweep_wr) begin
            fifo_we    = 1'b1;
            fifo_waddr = {r_sw_cls, IW'(r_sw_cnt)};
            fifo_wdata = SLOT_W'(r_sw_cnt);
            busy_we    = 1'b1;
            busy_waddr = {r_sw_cls, IW'(r_sw_cnt)};
            busy_wdata = 1'b0;
        end else begin
            fifo_we    = commit && free_ok;
            fifo_waddr = {r_cls, tail};
            fifo_wdata = r_slot_in;
            busy_we    = commit && exec_ok;
            busy_waddr = alloc_ok ? {r_cls, IW'(fifo_rdata)} : {r_cls, IW'(r_slot_in)};
            busy_wdata = alloc_ok;
        end
    end

    // free-list memory, one queue region per class
    scpa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (fifo_waddr),
        .i_wdata (fifo_wdata),
        .i_re    (in_fire),
        .i_raddr (fifo_raddr),
        .o_rdata (fifo_rdata)
    );

    // busy-bit memory, one bit per class slot
    scpa_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_busy_ram (
        .i_clk   (i_clk),
        .i_we    (busy_we),
        .i_waddr (busy_waddr),
        .i_wdata (busy_wdata),
        .i_re    (in_fire),
        .i_raddr (busy_raddr),
        .o_rdata (busy_rdata)
    );

    // an accepted beat always moves on to the execute cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    // a commit always leaves a response pending
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("commit did not load the output register");

    // the sweep never runs past the last slot of the class
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_sw_cnt <= r_sw_last))
        else $error("sweep counter beyond slot count");

    // a request and a configuration write never land in the same cycle
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> !cfg_fire)
        else $error("request and configuration beat accepted together");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Testbench for size_class_pool_allocator_core: random and directed alloc/free beats,
// checked against a behavioral mirror of the class free lists.
// Depends on scpa_pkg, the three channel interfaces and the allocator RTL.
`timescale 1ns / 1ps

module tb_top;
    import scpa_pkg::*;

    localparam int N_CLASSES    = 4;
    localparam int N_SLOTS      = 256;
    localparam int CLK_HALF     = 4;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 95;
    localparam int MAX_REQ      = (1 << REQ_W) - 1;

    // register indexes: sizes first, then slot counts, the rest unused
    localparam int REG_SIZE0   = 0;
    localparam int REG_SLOTS0  = 4;
    localparam int REG_NONE_LO = 8;
    localparam int REG_NONE_HI = (1 << CFG_IDX_W) - 1;

    localparam int unsigned BYTES_MASK = (32'd1 << BYTES_W) - 1;
    localparam int unsigned DATA_MASK  = (32'd1 << CFG_DATA_W) - 1;
    localparam int unsigned CNT_MASK   = (32'd1 << CNT_W) - 1;

    // mirror of the allocator state plus the responses it predicts
    class pool_mirror;
        int unsigned     size_reg[N_CLASSES];
        int unsigned     slots_reg[N_CLASSES];
        bit [SLOT_W-1:0] free_list[N_CLASSES][N_SLOTS];
        int unsigned     head[N_CLASSES];
        int unsigned     fill[N_CLASSES];
        bit              busy[N_CLASSES][N_SLOTS];
        int unsigned     free_bytes[N_CLASSES];
        t_status         want_status[$];
        int unsigned     want_class[$];
        int unsigned     want_slot[$];
        int unsigned     want_bytes[$];
        int              mismatches;
        int              seen;

        function int unsigned slot_cap(int unsigned n);
            return (n > N_SLOTS) ? N_SLOTS : n;
        endfunction

        task log_mismatch(string what);
            mismatches++;
            $display("mismatch at response %0d: %s", seen, what);
        endtask

        function int pending();
            return want_status.size();
        endfunction

        // register write beat
        function void note_write(int idx, int unsigned data);
            int c;
            data = data & DATA_MASK;
            if (idx >= REG_SIZE0 && idx < REG_SLOTS0) begin
                c = idx - REG_SIZE0;
                size_reg[c] = data;
                free_bytes[c] = (size_reg[c] * fill[c]) & BYTES_MASK;
            end else if (idx >= REG_SLOTS0 && idx < REG_NONE_LO) begin
                // count write rebuilds the free list in slot order
                c = idx - REG_SLOTS0;
                slots_reg[c] = data & CNT_MASK;
                fill[c] = slot_cap(slots_reg[c]);
                head[c] = 0;
                for (int i = 0; i < N_SLOTS; i++) begin
                    busy[c][i] = 1'b0;
                    if (i < fill[c]) free_list[c][i] = SLOT_W'(i);
                end
                free_bytes[c] = (size_reg[c] * fill[c]) & BYTES_MASK;
            end
        endfunction

        // accepted request beat: update the mirror and queue its response
        function void note_request(logic [KIND_W-1:0] kind, logic [REQ_W-1:0] req,
                                   logic [CLS_W-1:0] fc, logic [SLOT_W-1:0] fs);
            t_status     st;
            int unsigned oc, os, ob, want, h, tail, lim;
            int          hit;
            st = ST_OK;
            oc = 0;
            os = 0;
            ob = 0;
            if (kind == KIND_ALLOC) begin
                want = req;
                want = (want + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
                // lowest matching class wins, exhausted or not
                hit = -1;
                for (int i = N_CLASSES - 1; i >= 0; i--) begin
                    if (size_reg[i] != 0 && size_reg[i] == want) hit = i;
                end
                if (hit < 0) begin
                    st = ST_NO_CLASS;
                end else if (fill[hit] == 0) begin
                    st = ST_EXHAUSTED;
                    oc = hit;
                    ob = free_bytes[hit];
                end else begin
                    h = head[hit];
                    os = free_list[hit][h];
                    head[hit] = (h + 1) % N_SLOTS;
                    fill[hit]--;
                    busy[hit][os] = 1'b1;
                    if (free_bytes[hit] >= size_reg[hit]) free_bytes[hit] -= size_reg[hit];
                    else free_bytes[hit] = 0;
                    oc = hit;
                    ob = free_bytes[hit];
                end
            end else begin
                oc = fc;
                os = fs;
                lim = slot_cap(slots_reg[fc]);
                if (fs >= lim || !busy[fc][fs] || fill[fc] >= N_SLOTS) begin
                    st = ST_NOT_ALLOC;
                end else begin
                    tail = (head[fc] + fill[fc]) % N_SLOTS;
                    free_list[fc][tail] = fs;
                    fill[fc]++;
                    busy[fc][fs] = 1'b0;
                    free_bytes[fc] = (free_bytes[fc] + size_reg[fc]) & BYTES_MASK;
                end
                ob = free_bytes[fc];
            end
            want_status.push_back(st);
            want_class.push_back(oc);
            want_slot.push_back(os);
            want_bytes.push_back(ob);
        endfunction

        // accepted response beat against the oldest prediction
        task check_response(t_status st, logic [CLS_W-1:0] oc,
                            logic [SLOT_W-1:0] os, logic [BYTES_W-1:0] ob);
            t_status     e_st;
            int unsigned e_oc, e_os, e_ob;
            seen++;
            if (want_status.size() == 0) begin
                log_mismatch($sformatf("no response expected, got status %0d class %0d slot %0d",
                                       st, oc, os));
                return;
            end
            e_st = want_status.pop_front();
            e_oc = want_class.pop_front();
            e_os = want_slot.pop_front();
            e_ob = want_bytes.pop_front();
            if (st != e_st) log_mismatch($sformatf("status %0d, want %0d", st, e_st));
            if (oc != e_oc) log_mismatch($sformatf("class %0d, want %0d", oc, e_oc));
            if (os != e_os) log_mismatch($sformatf("slot %0d, want %0d", os, e_os));
            if (ob != e_ob) log_mismatch($sformatf("bytes_free %0d, want %0d", ob, e_ob));
        endtask

        // random allocated slot of a class, or -1
        function int pick_busy(int c);
            int taken[$];
            int lim;
            lim = slot_cap(slots_reg[c]);
            for (int i = 0; i < lim; i++) begin
                if (busy[c][i]) taken.push_back(i);
            end
            if (taken.size() == 0) return -1;
            return taken[$urandom_range(taken.size() - 1)];
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;
    int   stall_cycles = 0;

    pool_mirror book = new;

    scpa_req_if req_bus ();
    scpa_rsp_if rsp_bus ();
    scpa_cfg_if cfg_bus ();

    size_class_pool_allocator_core #(
        .NUM_CLASSES    (N_CLASSES),
        .SLOTS_PER_CLASS(N_SLOTS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus),
        .i_cfg  (cfg_bus)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // response sink with random back-pressure
    always @(posedge i_clk) begin
        rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            book.check_response(t_status'(rsp_bus.status), rsp_bus.out_class,
                                rsp_bus.out_slot, rsp_bus.bytes_free);
        end
    end

    // cycles since the last beat on any channel
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // watchdog
    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("tb_top failed");
        $finish;
    end

    // one request beat, with random sender gaps in front
    task automatic issue_request(logic [KIND_W-1:0] kind, int req, int cls, int slot);
        logic [REQ_W-1:0]  size_f;
        logic [CLS_W-1:0]  cls_f;
        logic [SLOT_W-1:0] slot_f;
        size_f = REQ_W'(req);
        cls_f  = CLS_W'(cls);
        slot_f = SLOT_W'(slot);
        while ($urandom_range(99) < snd_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.kind       <= kind;
        req_bus.req_size   <= size_f;
        req_bus.free_class <= cls_f;
        req_bus.free_slot  <= slot_f;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        book.note_request(kind, size_f, cls_f, slot_f);
    endtask

    // register write beat; valid stays up for a following write
    task automatic write_reg(int idx, int unsigned data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= CFG_IDX_W'(idx);
        cfg_bus.data  <= CFG_DATA_W'(data);
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        book.note_write(idx, data);
    endtask

    // stop sending and wait for every predicted response
    task automatic settle();
        req_bus.valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_size();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 65536;
            2:       return ALIGN_BYTES;
            3:       return $urandom_range(1, DATA_MASK);
            4:       return ALIGN_BYTES * $urandom_range(1, 16384);
            default: return ALIGN_BYTES * $urandom_range(1, 24);
        endcase
    endfunction

    function automatic int unsigned pick_count();
        case ($urandom_range(9))
            0:       return 0;
            1:       return MAX_SLOTS;
            2:       return $urandom_range(MAX_SLOTS + 1, CNT_MASK);
            3:       return $urandom_range(0, DATA_MASK);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    // new class setting between phases, only while the block is idle
    task automatic random_setup(bit every_reg);
        for (int c = 0; c < N_CLASSES; c++) begin
            if (every_reg || $urandom_range(3) != 0) write_reg(REG_SIZE0 + c, pick_size());
        end
        for (int c = 0; c < N_CLASSES; c++) begin
            if (every_reg || $urandom_range(9) < 6) write_reg(REG_SLOTS0 + c, pick_count());
        end
        // size change on a partly used list
        if ($urandom_range(3) == 0) write_reg(REG_SIZE0 + $urandom_range(N_CLASSES - 1),
                                              pick_size());
        if ($urandom_range(4) == 0) write_reg($urandom_range(REG_NONE_LO, REG_NONE_HI), $urandom);
        cfg_bus.valid <= 1'b0;
    endtask

    // mostly well-formed allocs and frees, some noise
    task automatic random_items(int count);
        int roll, c, k, s, req;
        repeat (count) begin
            roll = $urandom_range(99);
            c = $urandom_range(N_CLASSES - 1);
            if (roll < 55) begin
                req = -1;
                for (k = 0; k < N_CLASSES && req < 0; k++) begin
                    s = book.size_reg[(c + k) % N_CLASSES];
                    if (s != 0 && s % ALIGN_BYTES == 0 && s <= MAX_REQ + 1) begin
                        req = s - $urandom_range(0, ALIGN_BYTES - 1);
                        if (req > MAX_REQ) req = MAX_REQ;
                    end
                end
                if (req < 0) req = $urandom_range(0, MAX_REQ);
                issue_request(KIND_ALLOC, req, $urandom_range(N_CLASSES - 1),
                              $urandom_range(N_SLOTS - 1));
            end else if (roll < 85) begin
                s = book.pick_busy(c);
                if (s < 0) s = $urandom_range(N_SLOTS - 1);
                issue_request(KIND_FREE, $urandom_range(0, MAX_REQ), c, s);
            end else begin
                issue_request(KIND_W'($urandom_range(1)), $urandom_range(0, MAX_REQ),
                              $urandom_range(N_CLASSES - 1), $urandom_range(N_SLOTS - 1));
            end
        end
        settle();
    endtask

    // stimulus
    initial begin
        i_rst_n            <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.kind       <= KIND_ALLOC;
        req_bus.req_size   <= '0;
        req_bus.free_class <= '0;
        req_bus.free_slot  <= '0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= '0;
        cfg_bus.data       <= '0;
        snd_idle_pct = 28;
        rcv_idle_pct = 80;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // nothing configured: no class, nothing allocated
        issue_request(KIND_ALLOC, 0, 0, 0);
        issue_request(KIND_FREE, 0, 0, 0);
        settle();

        // duplicate sizes, largest size, an empty class, ignored indexes
        write_reg(REG_SIZE0 + 0, ALIGN_BYTES);
        write_reg(REG_SIZE0 + 1, 65536);
        write_reg(REG_SIZE0 + 2, ALIGN_BYTES);
        write_reg(REG_SIZE0 + 3, 2 * ALIGN_BYTES);
        write_reg(REG_SLOTS0 + 0, 2);
        write_reg(REG_SLOTS0 + 1, MAX_SLOTS);
        write_reg(REG_SLOTS0 + 2, 3);
        write_reg(REG_SLOTS0 + 3, 0);
        write_reg(REG_NONE_LO, DATA_MASK);
        write_reg(REG_NONE_HI, 5);
        cfg_bus.valid <= 1'b0;

        issue_request(KIND_ALLOC, 1, 0, 0);
        issue_request(KIND_ALLOC, 4, 0, 0);
        // lowest class exhausted although class 2 matches too
        issue_request(KIND_ALLOC, 3, 0, 0);
        issue_request(KIND_ALLOC, MAX_REQ, 3, 255);
        issue_request(KIND_ALLOC, MAX_REQ - 2, 0, 0);
        issue_request(KIND_ALLOC, 8, 0, 0);
        issue_request(KIND_ALLOC, 12, 0, 0);
        issue_request(KIND_FREE, 0, 0, 1);
        // double free, slot past the count
        issue_request(KIND_FREE, 0, 0, 1);
        issue_request(KIND_FREE, 0, 0, 2);
        issue_request(KIND_FREE, MAX_REQ, 0, 255);
        issue_request(KIND_ALLOC, 2, 0, 0);
        issue_request(KIND_FREE, 0, 1, 0);
        issue_request(KIND_FREE, 0, 1, 255);
        issue_request(KIND_FREE, 0, 2, 0);
        issue_request(KIND_FREE, 0, 3, 0);
        settle();

        // disable class 0, resize a partly used class, saturating count
        write_reg(REG_SIZE0 + 0, 0);
        write_reg(REG_SIZE0 + 1, 16);
        write_reg(REG_SIZE0 + 3, DATA_MASK);
        write_reg(REG_SLOTS0 + 3, CNT_MASK);
        cfg_bus.valid <= 1'b0;

        issue_request(KIND_ALLOC, 4, 0, 0);
        issue_request(KIND_ALLOC, 16, 0, 0);
        issue_request(KIND_FREE, 0, 1, 1);
        issue_request(KIND_FREE, 0, 0, 0);
        issue_request(KIND_ALLOC, MAX_REQ, 0, 0);
        issue_request(KIND_FREE, 0, 3, 255);
        settle();

        // random phases under three idling patterns
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    snd_idle_pct = 28;
                    rcv_idle_pct = 80;
                end
                1: begin
                    snd_idle_pct = 80;
                    rcv_idle_pct = 28;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (int ph = 0; ph < PHASES; ph++) begin
                random_setup(mode == 0 && ph == 0);
                random_items(PHASE_ITEMS);
            end
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.pending() != 0) book.log_mismatch("responses still outstanding");
        if (book.mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
